// ----- rtl/core/fcgi_pkg.sv -----
package fcgi_pkg;

  // Record types that carry forwarded content
  localparam logic [7:0] REC_STDOUT = 8'd6;
  localparam logic [7:0] REC_STDERR = 8'd7;

  // Header byte indices
  localparam logic [2:0] HDR_TYPE_POS  = 3'd1;
  localparam logic [2:0] HDR_LENHI_POS = 3'd4;
  localparam logic [2:0] HDR_LENLO_POS = 3'd5;
  localparam logic [2:0] HDR_PAD_POS   = 3'd6;
  localparam logic [2:0] HDR_LAST_POS  = 3'd7;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // Width of the packed result tdata: payload, error flag, drop flag, zero fill
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_CONTENT = 4'b0010,
    PH_PADDING = 4'b0100,
    PH_ENDED   = 4'b1000
  } phase_t;

  // One result beat produced by the parser
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] payload_byte;
    logic       from_error_stream;
    logic       drop_earlier;
    logic       record_last;
  } fcgi_res_t;

  // Parser status seen by the top level
  typedef struct packed {
    logic ended;
    logic error_mode;
  } fcgi_stat_t;

endpackage

// ----- rtl/core/fcgi_rec_parse.sv -----
module fcgi_rec_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   beat_en,
  input  logic [7:0]             data_byte,
  output fcgi_pkg::fcgi_res_t    res,
  output fcgi_pkg::fcgi_stat_t   stat
);
  import fcgi_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hdr_pos_r, hdr_pos_nxt;
  logic [7:0]  rec_type_r, rec_type_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] content_left_r, content_left_nxt;
  logic [7:0]  pad_left_r, pad_left_nxt;
  logic        err_mode_r, err_mode_nxt;
  logic        err_pend_r, err_pend_nxt;
  logic [15:0] content_dec;
  logic        content_done;

  assign content_dec  = content_left_r - 16'd1;
  assign content_done = (content_dec == 16'd0);

  // Next state and result for one byte
  always_comb begin
    phase_nxt        = phase_r;
    hdr_pos_nxt      = hdr_pos_r;
    rec_type_nxt     = rec_type_r;
    len_hi_nxt       = len_hi_r;
    content_left_nxt = content_left_r;
    pad_left_nxt     = pad_left_r;
    err_mode_nxt     = err_mode_r;
    err_pend_nxt     = err_pend_r;
    res              = '0;
    case (phase_r)
      PH_HEADER: begin
        hdr_pos_nxt = hdr_pos_r + 3'd1;
        case (hdr_pos_r)
          HDR_TYPE_POS:  rec_type_nxt = data_byte;
          HDR_LENHI_POS: len_hi_nxt = data_byte;
          HDR_LENLO_POS: content_left_nxt = {len_hi_r, data_byte};
          HDR_PAD_POS:   pad_left_nxt = data_byte;
          HDR_LAST_POS: begin
            if (content_left_r == 16'd0) begin
              // zero length record closes the stream
              phase_nxt             = PH_ENDED;
              res.valid             = 1'b1;
              res.kind              = KIND_END;
              res.from_error_stream = err_mode_r;
            end else begin
              if (rec_type_r == REC_STDERR && !err_mode_r) begin
                err_mode_nxt = 1'b1;
                err_pend_nxt = 1'b1;
              end
              phase_nxt = PH_CONTENT;
            end
          end
          default: ;
        endcase
      end
      PH_CONTENT: begin
        content_left_nxt = content_dec;
        if (rec_type_r == REC_STDERR) begin
          res.valid             = 1'b1;
          res.kind              = KIND_PAYLOAD;
          res.payload_byte      = data_byte;
          res.from_error_stream = 1'b1;
          res.drop_earlier      = err_pend_r;
          res.record_last       = content_done;
          err_pend_nxt          = 1'b0;
        end else if (rec_type_r == REC_STDOUT && !err_mode_r) begin
          res.valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = data_byte;
          res.record_last  = content_done;
        end
        if (content_done) begin
          phase_nxt = (pad_left_r != 8'd0) ? PH_PADDING : PH_HEADER;
        end
      end
      PH_PADDING: begin
        pad_left_nxt = pad_left_r - 8'd1;
        if (pad_left_r == 8'd1) begin
          phase_nxt = PH_HEADER;
        end
      end
      default: ;
    endcase
    if (!beat_en) begin
      res.valid = 1'b0;
    end
  end

  // State registers advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      hdr_pos_r      <= 3'd0;
      rec_type_r     <= 8'd0;
      len_hi_r       <= 8'd0;
      content_left_r <= 16'd0;
      pad_left_r     <= 8'd0;
      err_mode_r     <= 1'b0;
      err_pend_r     <= 1'b0;
    end else if (beat_en) begin
      phase_r        <= phase_nxt;
      hdr_pos_r      <= hdr_pos_nxt;
      rec_type_r     <= rec_type_nxt;
      len_hi_r       <= len_hi_nxt;
      content_left_r <= content_left_nxt;
      pad_left_r     <= pad_left_nxt;
      err_mode_r     <= err_mode_nxt;
      err_pend_r     <= err_pend_nxt;
    end
  end

  assign stat.ended      = (phase_r == PH_ENDED);
  assign stat.error_mode = err_mode_r;

endmodule

// ----- rtl/core/fastcgi_record_deframer.sv -----
// Channel  | Ports                         | Beat contents
// ---------+-------------------------------+-------------------------------------------
// in       | in_tvalid/in_tready/in_tdata  | one raw byte of the record stream
// out      | out_tvalid/out_tready/out_*   | payload byte or end marker, flags, tlast
//
// One byte is taken per cycle while in_tready is high; header, content and padding
// counters update in the same cycle and any result lands in a single output register.
// Zero or one result per byte; a result shows on the output in the cycle after its byte is taken.
// rst_n is synchronous, active low, and returns the parser to the header phase.
// The input stalls only while the output register is full and not being taken.
module fastcgi_record_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] data_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fcgi_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] payload_byte,
                                                       // [8] from_error_stream,
                                                       // [9] drop_earlier, [15:10] zero
  output logic                             out_tuser,  // [0] result_kind
  output logic                             out_tlast   // record_last
);
  import fcgi_pkg::*;

  logic       in_beat;
  fcgi_res_t  res;
  fcgi_stat_t stat;

  logic       out_valid_r;
  logic       out_kind_r;
  logic [7:0] out_byte_r;
  logic       out_err_r;
  logic       out_drop_r;
  logic       out_last_r;

  // Accept whenever the output register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  fcgi_rec_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_en   (in_beat),
    .data_byte (in_tdata),
    .res       (res),
    .stat      (stat)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && res.valid) begin
      out_kind_r <= res.kind;
      out_byte_r <= res.payload_byte;
      out_err_r  <= res.from_error_stream;
      out_drop_r <= res.drop_earlier;
      out_last_r <= res.record_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 10){1'b0}}, out_drop_r, out_err_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // An end marker in the output register means the parser has stopped
  a_end_means_ended: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_END) |-> stat.ended)
    else $error("end marker shown while parser still running");

  // Once ended, the parser stays ended until reset
  a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stat.ended |=> stat.ended)
    else $error("parser left ended phase without reset");

  // A drop flag only comes with error mode set
  a_drop_needs_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drop_r) |-> (stat.error_mode && out_err_r))
    else $error("drop flag without error mode");

endmodule
